// ----- rtl/wsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfr_pkg
// Shared types and constants of the WebSocket frame receiver.
// ----------------------------------------------------------------------------
package wsfr_pkg;

	localparam int ACCUM_WIDTH_DEFAULT = 27;

	localparam int MAX_FRAME_W   = 24;
	localparam int MAX_MESSAGE_W = 26;
	localparam int CFG_DATA_W    = 26;
	localparam int TDATA_OUT_W   = 24;

	localparam logic [MAX_FRAME_W-1:0]   MAX_FRAME_RST   = 24'd1048576;
	localparam logic [MAX_MESSAGE_W-1:0] MAX_MESSAGE_RST = 26'd4194304;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_MAX_FRAME   = 1'b0,
		REG_MAX_MESSAGE = 1'b1
	} reg_index_t;

	// frame opcodes
	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	// short length codes of the second header byte
	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	typedef enum logic [3:0] {
		V_MID            = 4'd0,
		V_MSG_DONE       = 4'd1,
		V_FRAG_STORED    = 4'd2,
		V_PING           = 4'd3,
		V_CLOSE          = 4'd4,
		V_IGNORED        = 4'd5,
		V_STRAY_CONT     = 4'd6,
		V_DATA_IN_FRAG   = 4'd7,
		V_MSG_TOO_LARGE  = 4'd8,
		V_FRAME_TOO_LARGE = 4'd9
	} verdict_t;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_LEN     = 3'd1,
		PH_LEN16   = 3'd2,
		PH_LEN64   = 3'd3,
		PH_MASK    = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_payload;
		logic [3:0] frame_op;
		logic       frame_final;
		logic       frame_end;
		verdict_t   verdict;
	} result_t;

endpackage

// ----- rtl/wsfr_parser.sv -----
// ----------------------------------------------------------------------------
// wsfr_parser
// Header parser, fragment bookkeeping and payload unmasking, one byte a cycle while take is high.
// ----------------------------------------------------------------------------
module wsfr_parser #(
	parameter int ACCUM_WIDTH = wsfr_pkg::ACCUM_WIDTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             take,
	input  logic [7:0]                       rx_byte,
	input  logic [wsfr_pkg::MAX_FRAME_W-1:0]   max_frame_len,
	input  logic [wsfr_pkg::MAX_MESSAGE_W-1:0] max_message_len,
	output logic                             res_valid,
	output wsfr_pkg::result_t                res
);
	import wsfr_pkg::*;

	localparam int CMP_W = ((ACCUM_WIDTH > MAX_MESSAGE_W) ? ACCUM_WIDTH : MAX_MESSAGE_W) + 1;
	localparam logic [CMP_W-1:0] ACCUM_MAX = CMP_W'({ACCUM_WIDTH{1'b1}});

	phase_t                   phase_q, phase_n;
	logic                     fin_q, fin_n;
	logic [3:0]               opcode_q, opcode_n;
	logic                     masked_q, masked_n;
	logic [MAX_FRAME_W-1:0]   len_q, len_n;
	logic                     big_q, big_n;
	logic [31:0]              mask_q, mask_n;
	logic [MAX_FRAME_W-1:0]   count_q, count_n;
	logic [ACCUM_WIDTH-1:0]   accum_q, accum_n;
	logic                     halted_q, halted_n;

	logic                     hd_go, fd_go;
	logic [CMP_W-1:0]         len_x, accum_x, sum_x;
	logic [7:0]               key;
	verdict_t                 err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			masked_q <= 1'b0;
			len_q    <= '0;
			big_q    <= 1'b0;
			mask_q   <= '0;
			count_q  <= '0;
			accum_q  <= '0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			fin_q    <= fin_n;
			opcode_q <= opcode_n;
			masked_q <= masked_n;
			len_q    <= len_n;
			big_q    <= big_n;
			mask_q   <= mask_n;
			count_q  <= count_n;
			accum_q  <= accum_n;
			halted_q <= halted_n;
		end
	end

	always_comb begin
		phase_n  = phase_q;
		fin_n    = fin_q;
		opcode_n = opcode_q;
		masked_n = masked_q;
		len_n    = len_q;
		big_n    = big_q;
		mask_n   = mask_q;
		count_n  = count_q;
		accum_n  = accum_q;
		halted_n = halted_q;
		hd_go    = 1'b0;
		fd_go    = 1'b0;
		err      = V_MID;
		key      = '0;
		res_valid = 1'b0;
		res.payload_byte = '0;
		res.has_payload  = 1'b0;
		res.frame_op     = opcode_q;
		res.frame_final  = fin_q;
		res.frame_end    = 1'b0;
		res.verdict      = V_MID;

		if (take && !halted_q) begin
			unique case (phase_q)
				PH_LEN: begin
					masked_n = rx_byte[7];
					count_n  = '0;
					len_n    = '0;
					big_n    = 1'b0;
					if (rx_byte[6:0] == LEN_CODE_16) begin
						phase_n = PH_LEN16;
					end else if (rx_byte[6:0] == LEN_CODE_64) begin
						phase_n = PH_LEN64;
					end else begin
						len_n = MAX_FRAME_W'(rx_byte[6:0]);
						if (rx_byte[7]) begin
							phase_n = PH_MASK;
							mask_n  = '0;
						end else begin
							hd_go = 1'b1;
						end
					end
				end
				PH_LEN16, PH_LEN64: begin
					len_n   = {len_q[MAX_FRAME_W-9:0], rx_byte};
					big_n   = big_q | (len_q[MAX_FRAME_W-1 -: 8] != 8'd0);
					count_n = count_q + 1'b1;
					if (count_n >= ((phase_q == PH_LEN16) ? MAX_FRAME_W'(2) : MAX_FRAME_W'(8)))
					begin
						if (masked_q) begin
							phase_n = PH_MASK;
							count_n = '0;
							mask_n  = '0;
						end else begin
							hd_go = 1'b1;
						end
					end
				end
				PH_MASK: begin
					mask_n  = {mask_q[23:0], rx_byte};
					count_n = count_q + 1'b1;
					if (count_n >= MAX_FRAME_W'(4)) begin
						hd_go = 1'b1;
					end
				end
				PH_PAYLOAD: begin
					// mask key byte 0 sits in the top byte of the key register
					key     = masked_q ? mask_q[{~count_q[1:0], 3'b000} +: 8] : 8'd0;
					count_n = count_q + 1'b1;
					res_valid        = 1'b1;
					res.payload_byte = rx_byte ^ key;
					res.has_payload  = 1'b1;
					if (count_n >= len_q) begin
						res.frame_end = 1'b1;
						fd_go         = 1'b1;
					end
				end
				default: begin
					// wait for a frame start; drop bytes with the top bit clear
					phase_n = PH_START;
					if (rx_byte[7]) begin
						fin_n    = 1'b1;
						opcode_n = rx_byte[3:0];
						phase_n  = PH_LEN;
					end
				end
			endcase
		end

		len_x   = CMP_W'(len_n);
		accum_x = CMP_W'(accum_q);
		sum_x   = accum_x + len_x;

		if (hd_go) begin
			count_n = '0;
			if (big_n || (len_n > max_frame_len)) begin
				err = V_FRAME_TOO_LARGE;
			end else if (opcode_q == OP_TEXT || opcode_q == OP_BIN) begin
				if (accum_q != '0) begin
					err = V_DATA_IN_FRAG;
				end else if (!fin_q && (len_x > CMP_W'(max_message_len))) begin
					err = V_MSG_TOO_LARGE;
				end
			end else if (opcode_q == OP_CONT) begin
				if (accum_q == '0) begin
					err = V_STRAY_CONT;
				end else if (sum_x > CMP_W'(max_message_len)) begin
					err = V_MSG_TOO_LARGE;
				end
			end
			if (err != V_MID) begin
				halted_n      = 1'b1;
				phase_n       = PH_START;
				res_valid     = 1'b1;
				res.frame_end = 1'b1;
				res.verdict   = err;
			end else if (len_n == '0) begin
				res_valid     = 1'b1;
				res.frame_end = 1'b1;
				fd_go         = 1'b1;
			end else begin
				phase_n = PH_PAYLOAD;
			end
		end

		if (fd_go) begin
			phase_n = PH_START;
			priority if (opcode_q == OP_TEXT || opcode_q == OP_BIN) begin
				if (fin_q) begin
					res.verdict = V_MSG_DONE;
				end else begin
					accum_n     = (len_x > ACCUM_MAX) ? ACCUM_MAX[ACCUM_WIDTH-1:0]
					                                 : len_x[ACCUM_WIDTH-1:0];
					res.verdict = V_FRAG_STORED;
				end
			end else if (opcode_q == OP_CONT) begin
				if (fin_q) begin
					accum_n     = '0;
					res.verdict = V_MSG_DONE;
				end else begin
					accum_n     = (sum_x > ACCUM_MAX) ? ACCUM_MAX[ACCUM_WIDTH-1:0]
					                                 : sum_x[ACCUM_WIDTH-1:0];
					res.verdict = V_FRAG_STORED;
				end
			end else if (opcode_q == OP_CLOSE) begin
				halted_n    = 1'b1;
				res.verdict = V_CLOSE;
			end else if (opcode_q == OP_PING) begin
				res.verdict = V_PING;
			end else begin
				res.verdict = V_IGNORED;
			end
		end
	end

endmodule

// ----- rtl/websocket_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_receiver_unit
// Receive-side WebSocket frame parser with payload unmasking.
// ----------------------------------------------------------------------------
// Feed the received bytes of an open link on the s_ side, one byte per
// transaction. The unit takes one byte every clock cycle while the skid
// register is free: header parsing, the size checks and the unmasking are
// settled in the cycle the byte is taken, and the result is registered in
// the output register, or in the skid register behind it while the output
// register is full. The skid keeps s_tready high for one more byte when
// m_tready drops, so s_tready depends only on registers. Header bytes give
// no result, except the last header byte of an empty frame or of a frame
// that fails a check. Each payload byte gives one result; the last result
// of every frame has m_tlast set and carries the verdict. An error or a
// close frame stops the unit: every later byte is taken and dropped until
// arst_n is asserted. Write the two size limits only while no byte is in flight.
module websocket_frame_receiver_unit #(
	parameter int ACCUM_WIDTH = wsfr_pkg::ACCUM_WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [wsfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// received bytes
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,    // [7:0] rx_byte
	// results
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [wsfr_pkg::TDATA_OUT_W-1:0] m_tdata, // [7:0] payload_byte,
	                                                  // [11:8] opcode,
	                                                  // [12] frame_final,
	                                                  // [16:13] verdict, rest zero
	output logic                          m_tuser,    // [0] has_payload
	output logic                          m_tlast     // frame_end
);
	import wsfr_pkg::*;

	logic [MAX_FRAME_W-1:0]   max_frame_q;
	logic [MAX_MESSAGE_W-1:0] max_message_q;

	logic    take;
	logic    res_valid;
	result_t res;

	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    pop;

	// Configuration registers: latch on the write enable, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q   <= MAX_FRAME_RST;
			max_message_q <= MAX_MESSAGE_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_MAX_FRAME:   max_frame_q   <= cfg_wdata[MAX_FRAME_W-1:0];
				REG_MAX_MESSAGE: max_message_q <= cfg_wdata[MAX_MESSAGE_W-1:0];
				default: ;
			endcase
		end
	end

	// Take a byte whenever the skid register is free.
	assign s_tready = !skid_valid_q;
	assign take     = s_tvalid && s_tready;

	wsfr_parser #(
		.ACCUM_WIDTH(ACCUM_WIDTH)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.rx_byte        (s_tdata),
		.max_frame_len  (max_frame_q),
		.max_message_len(max_message_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	assign pop = out_valid_q && m_tready;

	// Output register plus skid: advance the skid into the output slot when
	// the slot frees up, otherwise park a new result in the skid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.verdict, out_q.frame_final, out_q.frame_op,
	                   out_q.payload_byte};
	assign m_tuser  = out_q.has_payload;
	assign m_tlast  = out_q.frame_end;

endmodule

// ----- bench/tb_websocket_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_receiver_unit
// Self-checking bench for the WebSocket frame receiver: streams framed,
// optionally masked bytes with random gaps on both sides, predicts every
// result from an internal parser model and compares field by field.
// ----------------------------------------------------------------------------
module tb_websocket_frame_receiver_unit;
	import wsfr_pkg::*;

	localparam int ACC_W         = ACCUM_WIDTH_DEFAULT;
	localparam logic [63:0] ACC_MAX = (64'd1 << ACC_W) - 64'd1;
	localparam int STUCK_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [3:0] OP_PONG = 4'hA;

	// encodings of the payload length on the wire
	typedef enum {LEN_SHORT, LEN_WIDE16, LEN_WIDE64} len_form_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	websocket_frame_receiver_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// wire bytes waiting to be sent, and results the parser model predicts
	logic [7:0] wire_bytes[$];
	result_t    parsed_q[$];

	// parser model state and its copy of the size limits
	phase_t          pr_phase;
	logic            pr_fin;
	logic [3:0]      pr_op;
	logic            pr_masked;
	logic [63:0]     pr_len;
	logic [31:0]     pr_key;
	logic [23:0]     pr_count;
	logic [63:0]     pr_accum;
	logic            pr_halted;
	logic [MAX_FRAME_W-1:0]   lim_frame   = MAX_FRAME_RST;
	logic [MAX_MESSAGE_W-1:0] lim_message = MAX_MESSAGE_RST;

	int  mismatches   = 0;
	int  results_seen = 0;
	int  bytes_taken  = 0;
	int  bytes_queued = 0;
	int  frames_sent  = 0;
	int  stuck_cycles = 0;
	bit  byte_taken   = 1'b0;
	bit  no_idle      = 1'b0;
	int  send_gap     = 0;
	int  recv_stall   = 0;
	string halt_kind  = "none";

	initial begin
		pr_phase  = PH_START;
		pr_fin    = 1'b0;
		pr_op     = 4'h0;
		pr_masked = 1'b0;
		pr_len    = '0;
		pr_key    = '0;
		pr_count  = '0;
		pr_accum  = '0;
		pr_halted = 1'b0;
	end

	task automatic flag_mismatch(input string field, input logic [7:0] got,
			input logic [7:0] want);
		$display("MISMATCH result %0d %s: got %0h want %0h", results_seen, field, got, want);
		mismatches++;
	endtask

	task automatic expect_out(input logic [7:0] data, input logic has, input logic last,
			input verdict_t v);
		result_t r;
		r.payload_byte = data;
		r.has_payload  = has;
		r.frame_op     = pr_op;
		r.frame_final  = pr_fin;
		r.frame_end    = last;
		r.verdict      = v;
		parsed_q = {parsed_q, r};
	endtask

	// Verdict of a frame that ended cleanly; keep the fragment length up to date.
	function automatic verdict_t close_out_frame();
		logic [64:0] sum;
		pr_phase = PH_START;
		case (pr_op)
			OP_TEXT, OP_BIN: begin
				if (pr_fin) return V_MSG_DONE;
				pr_accum = (pr_len > ACC_MAX) ? ACC_MAX : pr_len;
				return V_FRAG_STORED;
			end
			OP_CONT: begin
				sum = {1'b0, pr_accum} + {1'b0, pr_len};
				pr_accum = (sum > {1'b0, ACC_MAX}) ? ACC_MAX : sum[63:0];
				if (pr_fin) begin
					pr_accum = '0;
					return V_MSG_DONE;
				end
				return V_FRAG_STORED;
			end
			OP_CLOSE: begin
				pr_halted = 1'b1;
				return V_CLOSE;
			end
			OP_PING: return V_PING;
			default: return V_IGNORED;
		endcase
	endfunction

	// All size and sequence checks are settled once the header is complete.
	task automatic check_header();
		verdict_t err;
		verdict_t v;
		err = V_MID;
		if (pr_len > {40'd0, lim_frame}) begin
			err = V_FRAME_TOO_LARGE;
		end else if (pr_op == OP_TEXT || pr_op == OP_BIN) begin
			if (pr_accum != 0) err = V_DATA_IN_FRAG;
			else if (!pr_fin && pr_len > {38'd0, lim_message}) err = V_MSG_TOO_LARGE;
		end else if (pr_op == OP_CONT) begin
			if (pr_accum == 0) err = V_STRAY_CONT;
			else if (pr_accum + pr_len > {38'd0, lim_message}) err = V_MSG_TOO_LARGE;
		end
		if (err != V_MID) begin
			pr_halted = 1'b1;
			pr_phase  = PH_START;
			expect_out(8'h00, 1'b0, 1'b1, err);
		end else begin
			pr_count = '0;
			if (pr_len == 0) begin
				v = close_out_frame();
				expect_out(8'h00, 1'b0, 1'b1, v);
			end else begin
				pr_phase = PH_PAYLOAD;
			end
		end
	endtask

	task automatic after_length();
		if (pr_masked) begin
			pr_phase = PH_MASK;
			pr_count = '0;
			pr_key   = '0;
		end else begin
			check_header();
		end
	endtask

	// Advance the parser model by one received byte.
	task automatic parse_rx_byte(input logic [7:0] b);
		logic [7:0] key;
		verdict_t v;
		if (!pr_halted) begin
			case (pr_phase)
				PH_LEN: begin
					pr_masked = b[7];
					pr_len    = '0;
					pr_count  = '0;
					if (b[6:0] == LEN_CODE_16) begin
						pr_phase = PH_LEN16;
					end else if (b[6:0] == LEN_CODE_64) begin
						pr_phase = PH_LEN64;
					end else begin
						pr_len = {57'd0, b[6:0]};
						after_length();
					end
				end
				PH_LEN16, PH_LEN64: begin
					pr_len   = {pr_len[55:0], b};
					pr_count = pr_count + 24'd1;
					if (pr_count >= ((pr_phase == PH_LEN16) ? 24'd2 : 24'd8)) after_length();
				end
				PH_MASK: begin
					pr_key   = {pr_key[23:0], b};
					pr_count = pr_count + 24'd1;
					if (pr_count >= 24'd4) check_header();
				end
				PH_PAYLOAD: begin
					// key bytes rotate from the most significant one down
					key = pr_masked ? 8'(pr_key >> (24 - 8 * int'(pr_count[1:0]))) : 8'h00;
					pr_count = pr_count + 24'd1;
					if ({40'd0, pr_count} >= pr_len) begin
						v = close_out_frame();
						expect_out(b ^ key, 1'b1, 1'b1, v);
					end else begin
						expect_out(b ^ key, 1'b1, 1'b0, V_MID);
					end
				end
				default: begin
					// drop bytes with the top bit clear while hunting for a frame start
					pr_phase = PH_START;
					if (b[7]) begin
						pr_fin   = 1'b1;
						pr_op    = b[3:0];
						pr_phase = PH_LEN;
					end
				end
			endcase
		end
	endtask

	// Check results and feed the model at each rising edge: results first,
	// since a byte taken now cannot have produced one yet.
	always @(posedge clk) begin : scoreboard
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (parsed_q.size() == 0) begin
					flag_mismatch("unexpected", m_tdata[7:0], 8'h00);
				end else begin
					want = parsed_q.pop_front();
					if (m_tdata[7:0] !== want.payload_byte)
						flag_mismatch("payload_byte", m_tdata[7:0], want.payload_byte);
					if (m_tuser !== want.has_payload)
						flag_mismatch("has_payload", 8'(m_tuser), 8'(want.has_payload));
					if (m_tdata[11:8] !== want.frame_op)
						flag_mismatch("frame_op", 8'(m_tdata[11:8]), 8'(want.frame_op));
					if (m_tdata[12] !== want.frame_final)
						flag_mismatch("frame_final", 8'(m_tdata[12]), 8'(want.frame_final));
					if (m_tlast !== want.frame_end)
						flag_mismatch("frame_end", 8'(m_tlast), 8'(want.frame_end));
					if (m_tdata[16:13] !== want.verdict)
						flag_mismatch("verdict", 8'(m_tdata[16:13]), 8'(want.verdict));
				end
			end
			byte_taken = s_tvalid && s_tready;
			if (byte_taken) begin
				bytes_taken++;
				parse_rx_byte(s_tdata);
			end
		end else begin
			byte_taken = 1'b0;
		end
	end

	// Sender: hold the byte until its transaction completes, then present the
	// next one or open a gap with s_tvalid low.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || byte_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (wire_bytes.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(1, 6) - 1;
				s_tvalid <= 1'b0;
			end else begin
				s_tdata  <= wire_bytes.pop_front();
				s_tvalid <= 1'b1;
			end
		end
	end

	// Receiver: drop m_tready at random, never in the last part.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			m_tready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			recv_stall = $urandom_range(1, 6) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// End the run when neither side completes a transaction for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
			else stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results pending",
					stuck_cycles, parsed_q.size());
				$display("tb_websocket_frame_receiver_unit NOT OK");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		wire_bytes = {wire_bytes, b};
		bytes_queued++;
	endtask

	// Queue one frame: random reserved bits, length encoding and mask key.
	// Leave out the body for frames that must stop at their header.
	task automatic queue_frame(input logic [3:0] op, input logic [63:0] len, input bit body);
		len_form_t form;
		bit masked;
		logic [6:0] code;
		if (len > 64'd65535) begin
			form = LEN_WIDE64;
		end else if (len > 64'd125) begin
			form = $urandom_range(0, 1) ? LEN_WIDE16 : LEN_WIDE64;
		end else begin
			case ($urandom_range(0, 3))
				0, 1: form = LEN_SHORT;
				2: form = LEN_WIDE16;
				default: form = LEN_WIDE64;
			endcase
		end
		masked = $urandom_range(0, 1);
		code = (form == LEN_SHORT) ? len[6:0] : (form == LEN_WIDE16) ? LEN_CODE_16 : LEN_CODE_64;
		send_byte({1'b1, 3'($urandom), op});
		send_byte({masked, code});
		if (form == LEN_WIDE16) begin
			for (int i = 1; i >= 0; i--) send_byte(len[8*i +: 8]);
		end else if (form == LEN_WIDE64) begin
			for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
		end
		if (masked) repeat (4) send_byte(8'($urandom));
		if (body) begin
			for (longint i = 0; i < longint'(len); i++) send_byte(8'($urandom));
		end
		frames_sent++;
	endtask

	// Opcodes other than close, which stops the unit: data, ping, pong and unknown ones.
	function automatic logic [3:0] pick_opcode();
		case ($urandom_range(0, 9))
			4, 5: return OP_BIN;
			6: return OP_PING;
			7: return OP_PONG;
			8: return 4'($urandom_range(0, 1) ? $urandom_range(3, 7) : $urandom_range(11, 15));
			default: return OP_TEXT;
		endcase
	endfunction

	// Mostly short payloads, sometimes exactly the frame limit or 400, whichever is smaller.
	function automatic logic [63:0] pick_len(input logic [MAX_FRAME_W-1:0] limit);
		int cap;
		cap = (limit > 400) ? 400 : int'(limit);
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return 64'(cap);
			8: return 64'($urandom_range(0, (cap < 125) ? cap : 125));
			9: return 64'($urandom_range(0, cap));
			default: return 64'($urandom_range(0, (cap < 12) ? cap : 12));
		endcase
	endfunction

	task automatic run_phase(input int budget);
		int start;
		start = bytes_queued;
		while (bytes_queued - start < budget) begin
			// drop-in noise between frames: bytes with the top bit clear
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 127)));
			queue_frame(pick_opcode(), pick_len(lim_frame), 1'b1);
		end
	endtask

	// Pause the sender until every byte is taken and every result is back,
	// then give header bytes still in flight time to clear.
	task automatic settle();
		while (wire_bytes.size() != 0 || s_tvalid) @(negedge clk);
		while (parsed_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_MAX_FRAME) lim_frame = val[MAX_FRAME_W-1:0];
		else lim_message = val[MAX_MESSAGE_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [63:0] big_len;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: noise at both ends of the dropped range, an empty text
		// frame, a masked binary frame with extreme bytes, a ping with a
		// 16-bit length and an empty pong with a 64-bit length.
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte({4'h8, OP_TEXT});
		send_byte({1'b0, 7'd0});
		send_byte({4'h8, OP_BIN});
		send_byte({1'b1, 7'd3});
		send_byte(8'hFF); send_byte(8'h00); send_byte(8'hA5); send_byte(8'h5A);
		send_byte(8'h00); send_byte(8'hFF); send_byte(8'h3C);
		send_byte({4'h8, OP_PING});
		send_byte({1'b0, LEN_CODE_16});
		send_byte(8'h00); send_byte(8'h01);
		send_byte(8'hFF);
		send_byte({4'hF, OP_PONG});
		send_byte({1'b0, LEN_CODE_64});
		repeat (8) send_byte(8'h00);
		frames_sent += 4;
		settle();

		// widest limits
		write_limit(REG_MAX_FRAME, 26'hFFFFFF);
		write_limit(REG_MAX_MESSAGE, 26'h3FFFFFF);
		run_phase(750);
		settle();

		// zero limits: only empty frames get through
		write_limit(REG_MAX_FRAME, '0);
		write_limit(REG_MAX_MESSAGE, '0);
		run_phase(150);
		settle();

		// tight limits, hit the frame limit exactly now and then
		write_limit(REG_MAX_FRAME, 26'($urandom_range(1, 125)));
		write_limit(REG_MAX_MESSAGE, 26'($urandom_range(0, 1000)));
		run_phase(450);
		settle();

		// last part without gaps, ending in a frame that stops the unit
		no_idle = 1'b1;
		write_limit(REG_MAX_FRAME, 26'($urandom_range(126, 500)));
		write_limit(REG_MAX_MESSAGE, 26'($urandom));
		run_phase(400);
		case ($urandom_range(0, 2))
			0: begin
				halt_kind = "close";
				queue_frame(OP_CLOSE, pick_len(lim_frame), 1'b1);
			end
			1: begin
				halt_kind = "stray continuation";
				queue_frame(OP_CONT, pick_len(lim_frame), 1'b0);
			end
			default: begin
				halt_kind = "frame too large";
				big_len = {$urandom, $urandom};
				if ($urandom_range(0, 1) || big_len <= {40'd0, lim_frame})
					big_len = {40'd0, lim_frame} + 64'd1;
				queue_frame(pick_opcode(), big_len, 1'b0);
			end
		endcase
		// the stopped unit must take these and stay silent
		repeat (20) send_byte(8'($urandom));
		settle();

		$display("covered %0d frames in %0d bytes taken, %0d results checked",
			frames_sent, bytes_taken, results_seen);
		$display("limit settings: 5, run stopped by a %s frame", halt_kind);
		if (mismatches == 0 && parsed_q.size() == 0) begin
			$display("tb_websocket_frame_receiver_unit OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches, parsed_q.size());
			$display("tb_websocket_frame_receiver_unit NOT OK");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/wsfr_pkg.sv
rtl/wsfr_parser.sv
rtl/websocket_frame_receiver_unit.sv
bench/tb_websocket_frame_receiver_unit.sv
